### src/gspa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gas sensor ppm averager.
// No dependencies; used by gas_sensor_ppm_averager_top, gspa_seg, gspa_chk and tb_top.

package gspa_pkg;

    // Samples per reading (default for the top level parameter)
    localparam int SAMPLES_PER_READING_DEF = 10;

    // Converter scaling: mv = floor(sample * 3300 / 4095)
    localparam logic [11:0] MV_SCALE    = 12'd3300;
    localparam int          MV_SHIFT    = 36;
    localparam logic [24:0] MV_RECIP    =
        25'(((64'd1 << MV_SHIFT) + 64'd4094) / 64'd4095);

    // Segment slopes are all expressed over 500 mV: floor(x / 500) for x < 2^23
    localparam int          DIV500_SHIFT = 32;
    localparam logic [23:0] DIV500_RECIP =
        24'(((64'd1 << DIV500_SHIFT) + 64'd499) / 64'd500);

    // Concentration limits
    localparam logic [12:0] FLOOR_MV  = 13'd1500;
    localparam logic [12:0] CEIL_MV   = 13'd4500;
    localparam logic [13:0] FLOOR_PPM = 14'd300;
    localparam logic [13:0] CEIL_PPM  = 14'd8500;

    // Linear segments: low bound exclusive, low + SEG_SPAN inclusive
    localparam int          SEG_COUNT = 6;
    localparam logic [12:0] SEG_SPAN  = 13'd500;
    localparam logic [12:0] SEG_LOW   [SEG_COUNT] =
        '{13'd1500, 13'd2000, 13'd2500, 13'd3000, 13'd3500, 13'd4000};
    localparam logic [12:0] SEG_OFF   [SEG_COUNT] =
        '{13'd1300, 13'd1400, 13'd1750, 13'd1750, 13'd2500, 13'd3500};
    // First slope is 180/250, kept as 360/500
    localparam logic [12:0] SEG_SLOPE [SEG_COUNT] =
        '{13'd360, 13'd270, 13'd750, 13'd1100, 13'd1600, 13'd4300};

    // Upper limit after reset
    localparam logic [13:0] UPPER_LIMIT_RST = 14'd3000;

    typedef enum logic [1:0] {
        SEG_FLOOR,
        SEG_RAMP,
        SEG_CEIL
    } t_seg_kind;

    typedef struct packed {
        t_seg_kind   kind;
        logic [22:0] prod;   // (v - offset) * slope, still to be divided by 500
    } t_seg_info;

endpackage

### src/gspa_seg.sv
`timescale 1ns / 1ps
// Segment selection for the concentration curve: picks the range of the
// voltage and forms the numerator of the ramp. Depends on gspa_pkg.

module gspa_seg (
    input  logic [12:0]          i_volt_mv,
    output gspa_pkg::t_seg_info  o_seg
);

    logic [12:0] offset;
    logic [12:0] slope;
    logic [12:0] diff;

    always_comb begin
        offset = '0;
        slope  = '0;
        for (int i = 0; i < gspa_pkg::SEG_COUNT; i++) begin
            if (i_volt_mv > gspa_pkg::SEG_LOW[i] &&
                i_volt_mv <= gspa_pkg::SEG_LOW[i] + gspa_pkg::SEG_SPAN) begin
                offset = gspa_pkg::SEG_OFF[i];
                slope  = gspa_pkg::SEG_SLOPE[i];
            end
        end
    end

    // Only used for the ramp, where the voltage is always above the offset
    assign diff = i_volt_mv - offset;

    always_comb begin
        if (i_volt_mv <= gspa_pkg::FLOOR_MV) begin
            o_seg.kind = gspa_pkg::SEG_FLOOR;
        end else if (i_volt_mv > gspa_pkg::CEIL_MV) begin
            o_seg.kind = gspa_pkg::SEG_CEIL;
        end else begin
            o_seg.kind = gspa_pkg::SEG_RAMP;
        end
        o_seg.prod = 23'(diff) * 23'(slope);
    end

endmodule

### src/gas_sensor_ppm_averager_top.sv
`timescale 1ns / 1ps
// Gas sensor averager: scales ADC samples to mV, averages a reading and maps
// it to ppm with an alarm flag. Depends on gspa_pkg and gspa_seg.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tdata[11:0] adc_sample
//  m_axis    out        m_axis_tvalid/tready         tdata[12:0] sensor_mv,
//                                                    [26:13] gas_ppm, [27] over_limit
//  cfg       in         i_cfg_wr_en                  i_cfg_wr_data upper_limit
//
// One sample is taken per cycle while s_axis_tready is high. Seven register
// stages (input, product, mV, sum, average, segment, result) carry the last
// sample of each reading through to its result. Each stage holds when its successor
// is full and stalled, so bubbles fill up and the input keeps taking transactions
// while a result waits. Synchronous reset empties the pipe, clears sum and count
// and sets the limit to 3000.

module gas_sensor_ppm_averager_top #(
    parameter int SAMPLES_PER_READING = gspa_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [12:0] sensor_mv, [26:13] gas_ppm,
                                        // [27] over_limit, [31:28] zero
    input  logic        i_cfg_wr_en,
    input  logic [13:0] i_cfg_wr_data
);

    localparam int CNT_W     = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int AVG_SHIFT = 16 + $clog2(SAMPLES_PER_READING);
    localparam logic [16:0] AVG_RECIP =
        17'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1)
            / 64'(SAMPLES_PER_READING));

    // stage enables, one per register stage
    logic en0, en1, en2, en3, en4, en5, en6;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic [11:0]          r_sample;
    logic [23:0]          r_prod;
    logic [11:0]          r_mv;
    logic [15:0]          r_sum;
    logic [15:0]          r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic [12:0]          r_volt;
    logic [12:0]          r_s5_volt;
    gspa_pkg::t_seg_info  r_s5_seg;
    logic [12:0]          r_out_mv;
    logic [13:0]          r_out_ppm;
    logic                 r_out_over;
    logic [13:0]          r_upper_limit;

    logic [23:0]          n_prod;
    logic [49:0]          mv_wide;
    logic [11:0]          n_mv;
    logic                 last_sample;
    logic [15:0]          n_sum;
    logic [39:0]          avg_wide;
    logic [12:0]          n_volt;
    gspa_pkg::t_seg_info  n_seg;
    logic [46:0]          ramp_wide;
    logic [13:0]          n_ppm;

    // ---------------------------------------------------------------- flow
    assign en6 = ~r_v6 | m_axis_tready;
    assign en5 = ~r_v5 | en6;
    assign en4 = ~r_v4 | en5;
    assign en3 = ~r_v3 | en4;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;
    assign en0 = ~r_v0 | en1;

    assign s_axis_tready = en0;
    assign m_axis_tvalid = r_v6;
    assign m_axis_tdata  = {4'd0, r_out_over, r_out_ppm, r_out_mv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en0) r_v0 <= s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            // only the last sample of a reading carries on
            if (en3) r_v3 <= r_v2 & last_sample;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= gspa_pkg::UPPER_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_upper_limit <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- scaling
    assign n_prod  = {12'd0, r_sample} * {12'd0, gspa_pkg::MV_SCALE};
    assign mv_wide = {26'd0, r_prod} * {25'd0, gspa_pkg::MV_RECIP};
    assign n_mv    = mv_wide[gspa_pkg::MV_SHIFT +: 12];

    always_ff @(posedge i_clk) begin
        if (en0) r_sample <= s_axis_tdata[11:0];
        if (en1) r_prod   <= n_prod;
        if (en2) r_mv     <= n_mv;
    end

    // ---------------------------------------------------------------- accumulate
    assign last_sample = (r_cnt == CNT_W'(SAMPLES_PER_READING - 1));
    assign n_sum       = r_acc + {4'd0, r_mv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_v2 && en3) begin
            if (last_sample) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= n_sum;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) r_sum <= n_sum;
    end

    // ---------------------------------------------------------------- average
    // exact floor(sum / N) for any 16-bit sum via reciprocal multiply
    assign avg_wide = {24'd0, r_sum} * {23'd0, AVG_RECIP};
    assign n_volt   = {avg_wide[AVG_SHIFT +: 12], 1'b0};

    always_ff @(posedge i_clk) begin
        if (en4) r_volt <= n_volt;
    end

    // ---------------------------------------------------------------- segments
    gspa_seg u_seg (
        .i_volt_mv (r_volt),
        .o_seg     (n_seg)
    );

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_seg  <= n_seg;
            r_s5_volt <= r_volt;
        end
    end

    // ---------------------------------------------------------------- result
    assign ramp_wide = {24'd0, r_s5_seg.prod} * {23'd0, gspa_pkg::DIV500_RECIP};

    always_comb begin
        unique case (r_s5_seg.kind)
            gspa_pkg::SEG_FLOOR: n_ppm = gspa_pkg::FLOOR_PPM;
            gspa_pkg::SEG_CEIL:  n_ppm = gspa_pkg::CEIL_PPM;
            gspa_pkg::SEG_RAMP:  n_ppm = ramp_wide[gspa_pkg::DIV500_SHIFT +: 14];
            default:             n_ppm = gspa_pkg::FLOOR_PPM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_out_mv   <= r_s5_volt;
            r_out_ppm  <= n_ppm;
            r_out_over <= (r_upper_limit <= n_ppm);
        end
    end

endmodule

### src/gspa_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the gas sensor averager, bound to the top level.
// Depends on gspa_pkg for the limit reset value.

module gspa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        i_cfg_wr_en,
    input logic [13:0] i_cfg_wr_data
);

    logic [13:0] r_lim;

    // mirror the limit register from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= gspa_pkg::UPPER_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_lim <= i_cfg_wr_data;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:0] <= 13'd6600 &&
                          m_axis_tdata[26:13] <= 14'd8600 &&
                          m_axis_tdata[31:28] == 4'd0)
        else $error("result field out of range");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12:0] <= 13'd1500 |-> m_axis_tdata[26:13] == 14'd300)
        else $error("low voltage not mapped to floor concentration");

    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[27] == (r_lim <= m_axis_tdata[26:13]))
        else $error("alarm flag disagrees with limit");

endmodule

bind gas_sensor_ppm_averager_top gspa_chk u_gspa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for gas_sensor_ppm_averager_top: feeds converter samples,
// predicts readings in SV or takes them from directed rows, and compares each result transaction field by field.
// Depends on gspa_pkg and the RTL under src/.

module tb_top;

    typedef struct packed {
        logic [12:0] mv;
        logic [13:0] ppm;
        logic        over;
    } t_reading;

    typedef struct {
        logic [11:0] sample;
        int          reps;
        bit          typed;
        t_reading    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_wr_en = 1'b0;
    logic [13:0] i_cfg_wr_data = '0;

    // predictor state
    logic [15:0] mv_sum;
    logic [3:0]  samples_taken;
    logic [13:0] alarm_limit;

    t_reading    pending_readings[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    gas_sensor_ppm_averager_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [11:0] adc_sample, [15:12] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [12:0] sensor_mv, [26:13] gas_ppm,
                                          // [27] over_limit, [31:28] zero
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned mv_of_sample(logic [11:0] s);
        return (int'(s) * 3300) / 4095;
    endfunction

    // later segments override earlier ones
    function automatic int unsigned ppm_for_voltage(int unsigned v);
        int unsigned p;
        p = 0;
        if (v < 1750) p = 300;
        if (v > 1500 && v <= 2000) p = (v - 1300) * 180 / 250;
        if (v > 2000 && v <= 2500) p = (v - 1400) * 270 / 500;
        if (v > 2500 && v <= 3000) p = (v - 1750) * 750 / 500;
        if (v > 3000 && v <= 3500) p = (v - 1750) * 1100 / 500;
        if (v > 3500 && v <= 4000) p = (v - 2500) * 1600 / 500;
        if (v > 4000 && v <= 4500) p = (v - 3500) * 4300 / 500;
        if (v > 4500) p = 8500;
        return p;
    endfunction

    task automatic accumulate_sample(input logic [11:0] s, output bit done,
                                     output t_reading r);
        int unsigned v;
        int unsigned p;
        mv_sum = mv_sum + 16'(mv_of_sample(s));
        samples_taken = samples_taken + 4'd1;
        done = (samples_taken == 4'd10);
        r = '0;
        if (done) begin
            v = (int'(mv_sum) / 10) * 2;
            p = ppm_for_voltage(v);
            r.mv = 13'(v);
            r.ppm = 14'(p);
            r.over = (alarm_limit <= 14'(p));
            mv_sum = '0;
            samples_taken = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [11:0] s, input bit typed,
                               input t_reading want);
        bit       done;
        t_reading r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accumulate_sample(s, done, r);
        if (done) pending_readings.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    // hold the input until every reading is out, then let the pipe empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [13:0] lim);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lim;
        alarm_limit = lim;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_reading();
        int          style;
        int          target_mv;
        int          centre;
        int          smp;
        logic [11:0] s;
        int          edges_mv[8] = '{750, 875, 1000, 1250, 1500, 1750, 2000, 2250};
        style = $urandom_range(99);
        if (style < 40) begin
            // land exactly on or beside a segment edge
            target_mv = edges_mv[$urandom_range(7)] + $urandom_range(2) - 1;
            s = 12'((target_mv * 4095 + 3299) / 3300);
            repeat (10) send_sample(s, 1'b0, '0);
        end else if (style < 85) begin
            centre = $urandom_range(4095);
            repeat (10) begin
                smp = centre + $urandom_range(40) - 20;
                if (smp < 0) smp = 0;
                if (smp > 4095) smp = 4095;
                send_sample(12'(smp), 1'b0, '0);
            end
        end else begin
            repeat (10) send_sample(12'($urandom_range(4095)), 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mv = m_axis_tdata[12:0];
            got.ppm = m_axis_tdata[26:13];
            got.over = m_axis_tdata[27];
            if (pending_readings.size() == 0) begin
                report_mismatch("result with none pending", int'(got.mv), -1);
            end else begin
                want = pending_readings.pop_front();
                if (got.mv !== want.mv) report_mismatch("sensor_mv", got.mv, want.mv);
                if (got.ppm !== want.ppm) report_mismatch("gas_ppm", got.ppm, want.ppm);
                if (got.over !== want.over)
                    report_mismatch("over_limit", got.over, want.over);
            end
        end
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_stim_row   dir_rows[4];
        int          idle_send[4];
        int          idle_recv[4];
        logic [13:0] phase_limit[4];

        idle_send   = '{0, 66, 0, 29};
        idle_recv   = '{0, 0, 66, 29};
        phase_limit = '{14'd8500, 14'd0, 14'h3FFF, 14'd300};

        // all-zero and full-scale readings under the reset limit
        dir_rows[0] = '{12'd0, 9, 1'b0, '0};
        dir_rows[1] = '{12'd0, 1, 1'b1, '{13'd0, 14'd300, 1'b0}};
        dir_rows[2] = '{12'hFFF, 9, 1'b0, '0};
        dir_rows[3] = '{12'hFFF, 1, 1'b1, '{13'd6600, 14'd8500, 1'b1}};

        mv_sum = '0;
        samples_taken = '0;
        alarm_limit = gspa_pkg::UPPER_LIMIT_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps)
                send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            write_limit(phase_limit[ph]);
            repeat (8) send_reading();
            drain_results();
            write_limit(14'($urandom_range(300, 8500)));
            repeat (7) send_reading();
        end

        drain_results();
        recv_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        while (pending_readings.size() != 0) begin
            void'(pending_readings.pop_front());
            report_mismatch("reading never returned", 0, 1);
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
